FILE: sv/cgk_pkg.sv
// ----------------------------------------------------------------------------
// cgk_pkg
// Shared types and constants for the CGK random walk window embedding.
// ----------------------------------------------------------------------------
package cgk_pkg;

  // window length register width and largest supported window
  localparam int LenW          = 5;
  localparam int MaxWindowDef  = 21;
  // step counter covers 3 * 21 = 63 walk steps
  localparam int StepW         = 6;
  localparam int WalkW         = 63;
  localparam int SymW          = 3;
  localparam int PosW          = 32;
  localparam int NumSym        = 5;
  localparam int CfgIdxW       = 3;

  // symbol codes
  localparam logic [SymW-1:0] SymN = 3'd4;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegWindowLen = 3'd0,
    RegWalkA     = 3'd1,
    RegWalkC     = 3'd2,
    RegWalkG     = 3'd3,
    RegWalkT     = 3'd4,
    RegWalkN     = 3'd5
  } cfg_reg_e;

  // input word
  typedef struct packed {
    logic [SymW-1:0] base;
    logic            string_end;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [SymW-1:0] embedded_symbol;
    logic [PosW-1:0] window_start;
    logic            last_of_window;
  } out_word_t;

  // configuration write word
  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [WalkW-1:0]   data;
  } cfg_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
  } cgk_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full_next;
    logic last_step;
    logic out_free;
  } cgk_status_t;

endpackage

FILE: sv/cgk_stream_if.sv
// ----------------------------------------------------------------------------
// cgk_stream_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface cgk_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/cgk_window_embedding_core.sv
// ----------------------------------------------------------------------------
// cgk_window_embedding_core
// CGK random walk embedding of a sliding window over a nucleotide stream.
// ----------------------------------------------------------------------------
// Until the window is full, an accepted symbol keeps the controller idle. Once
// it holds k symbols, the symbol is followed by a run of 3k result words, one
// per cycle from a single walk pointer over the window shift line while the
// result side does not stall the output register; no new symbol is taken
// until the run ends. Configuration writes are taken every cycle and
// belong only in idle periods. Unwritten walk rows read as zero, so the
// pointer never advances and padding never starts before the window end.
module cgk_window_embedding_core import cgk_pkg::*; #(
  parameter int MaxWindow = MaxWindowDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  cgk_stream_if.sink   in_i,
  cgk_stream_if.sink   cfg_i,
  cgk_stream_if.source out_o
);

  cgk_cmd_t    cmd;
  cgk_status_t status;
  in_word_t    in_word;
  cfg_word_t   cfg_word;
  out_word_t   out_word;

  assign in_word       = in_i.payload;
  assign cfg_word      = cfg_i.payload;
  assign out_o.payload = out_word;

  // controller
  cgk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  cgk_dpath #(
    .MaxWindow (MaxWindow)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_word_i  (cfg_word),
    .cfg_ready_o (cfg_i.ready),
    .in_word_i   (in_word),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_word),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

FILE: sv/cgk_ctrl.sv
// ----------------------------------------------------------------------------
// cgk_ctrl
// Controller: accepts a word when idle and sequences the walk steps.
// ----------------------------------------------------------------------------
module cgk_ctrl import cgk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cgk_status_t status_i,
  output cgk_cmd_t    cmd_o
);

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e state_q;

  // commands
  assign in_ready_o  = (state_q == StIdle);
  assign cmd_o.load  = in_valid_i && in_ready_o;
  assign cmd_o.step  = (state_q == StRun) && status_i.out_free;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (cmd_o.load && status_i.full_next) state_q <= StRun;
        end
        StRun: begin
          if (cmd_o.step && status_i.last_step) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

FILE: sv/cgk_dpath.sv
// ----------------------------------------------------------------------------
// cgk_dpath
// Datapath: config registers, window shift line, walk pointer, result register.
// ----------------------------------------------------------------------------
module cgk_dpath import cgk_pkg::*; #(
  parameter int MaxWindow = MaxWindowDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  input  cfg_word_t   cfg_word_i,
  output logic        cfg_ready_o,
  // input word
  input  in_word_t    in_word_i,
  // result word
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_word_o,
  // control
  input  cgk_cmd_t    cmd_i,
  output cgk_status_t status_o
);

  localparam int FillW = $clog2(MaxWindow + 1);
  localparam int IdxW  = (MaxWindow > 1) ? $clog2(MaxWindow) : 1;

  logic [LenW-1:0]  win_len_q;
  logic [WalkW-1:0] walk_q [NumSym];
  logic [SymW-1:0]  store_q [MaxWindow];
  logic [FillW-1:0] fill_q;
  logic [PosW-1:0]  pos_q;
  logic [PosW-1:0]  start_q;
  logic [LenW-1:0]  ptr_q;
  logic [StepW-1:0] step_q;
  logic             out_valid_q;
  out_word_t        out_q;

  logic [LenW-1:0]  k;
  logic [SymW-1:0]  sym_in;
  logic [FillW-1:0] fill_d;
  logic [StepW-1:0] steps;
  logic [LenW:0]    idx_sum;
  logic [IdxW-1:0]  idx;
  logic             in_win;
  logic [SymW-1:0]  sym_cur;
  logic [WalkW-1:0] walk_row;
  logic             adv;

  // effective window length clamped to 1..MaxWindow
  always_comb begin
    k = win_len_q;
    if (k == '0) k = LenW'(1);
    if (k > LenW'(MaxWindow)) k = LenW'(MaxWindow);
  end

  // incoming symbol, codes above N read as N
  assign sym_in = (in_word_i.base > SymN) ? SymN : in_word_i.base;

  // saturating fill count
  assign fill_d = (fill_q == FillW'(MaxWindow)) ? fill_q : fill_q + FillW'(1);

  // walk step selection
  assign steps    = StepW'({1'b0, k}) + StepW'({k, 1'b0});
  assign idx_sum  = (LenW + 1)'(MaxWindow) - {1'b0, k} + {1'b0, ptr_q};
  assign idx      = idx_sum[IdxW-1:0];
  assign in_win   = (ptr_q < k);
  assign sym_cur  = in_win ? store_q[idx] : SymN;
  assign walk_row = walk_q[sym_cur];
  assign adv      = in_win && walk_row[step_q];

  // status to controller
  assign status_o.full_next = (LenW'(fill_d) >= k);
  assign status_o.last_step = (step_q == steps - StepW'(1));
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= LenW'(MaxWindowDef);
      for (int i = 0; i < NumSym; i++) walk_q[i] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_word_i.index)
        RegWindowLen: win_len_q <= cfg_word_i.data[LenW-1:0];
        RegWalkA:     walk_q[0] <= cfg_word_i.data;
        RegWalkC:     walk_q[1] <= cfg_word_i.data;
        RegWalkG:     walk_q[2] <= cfg_word_i.data;
        RegWalkT:     walk_q[3] <= cfg_word_i.data;
        RegWalkN:     walk_q[4] <= cfg_word_i.data;
        default: ;
      endcase
    end
  end

  // window shift line, newest symbol at the top entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < MaxWindow - 1; i++) store_q[i] <= store_q[i+1];
      store_q[MaxWindow-1] <= sym_in;
    end
  end

  // fill count and string position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      pos_q  <= '0;
    end else if (cmd_i.load) begin
      fill_q <= in_word_i.string_end ? '0 : fill_d;
      pos_q  <= in_word_i.string_end ? '0 : pos_q + PosW'(1);
    end
  end

  // walk pointer and step counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      start_q <= pos_q - PosW'(k) + PosW'(1);
      ptr_q   <= '0;
      step_q  <= '0;
    end else if (cmd_i.step) begin
      if (adv) ptr_q <= ptr_q + LenW'(1);
      step_q <= step_q + StepW'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_q.embedded_symbol <= sym_cur;
      out_q.window_start    <= start_q;
      out_q.last_of_window  <= status_o.last_step;
    end
  end

endmodule
